FILE: hdl/bitmap_first_fit_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion helpers for the allocator.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_CORE_ASSERT_SVH

// Asserts that a condition implies another on the same edge.
`define BFA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Asserts that a condition implies another on the next edge.
`define BFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// Allocator package
// Types and constants shared by the allocator modules.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int unsigned MAP_BYTES_DEF = 512;
  localparam int unsigned GRANULE_BYTES = 4;
  localparam logic [31:0] USER_BASE_RST = 32'h00FF89C0;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NO_SPACE    = 2'd1;
  localparam logic [1:0] ST_BAD_ADDRESS = 2'd2;

  // A classified command handed from the front to the back.
  typedef struct packed {
    logic        is_free;
    logic        bad;
    logic [10:0] need;
    logic [29:0] first;
  } cmd_t;

endpackage

FILE: hdl/bfa_if.sv
// ----------------------------------------------------------------------------
// Allocator channels
// Valid/ready channels for request and result words.
// ----------------------------------------------------------------------------
interface bfa_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [9:0]  size_bytes;
  logic [31:0] address;
  modport source (output valid, func, size_bytes, address, input ready);
  modport sink (input valid, func, size_bytes, address, output ready);
endinterface

interface bfa_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_address;
  logic [1:0]  status;
  modport source (output valid, block_address, status, input ready);
  modport sink (input valid, block_address, status, output ready);
endinterface

FILE: hdl/bitmap_first_fit_allocator_core.sv
// ----------------------------------------------------------------------------
// Bitmap first-fit allocator
// Each request word is worked through granule by granule: allocate scans
// the bitmap RAM one granule a cycle, with a read state before each byte,
// then marks the run with read, write and wait states per granule (no wait
// state at a byte boundary); free marks its run the same way. After reset
// the bitmap RAM is cleared byte by byte, during which the engine takes no
// command. A two-entry queue separates decode from the bitmap engine.
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator_core
  import bfa_pkg::*;
#(
  parameter int unsigned MAP_BYTES = MAP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  bfa_req_if.sink     in_req,
  bfa_rsp_if.source   out_rsp
);
  logic [31:0] user_base_r;
  logic        cmd_valid, cmd_ready;
  cmd_t        cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      user_base_r <= USER_BASE_RST;
    end else if (cfg_we) begin
      user_base_r <= cfg_wdata;
    end
  end

  bfa_front #(.MAP_BYTES(MAP_BYTES)) u_front (
    .clk(clk), .rst_n(rst_n), .user_base(user_base_r), .req(in_req),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  bfa_back #(.MAP_BYTES(MAP_BYTES)) u_back (
    .clk(clk), .rst_n(rst_n), .user_base(user_base_r),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd), .rsp(out_rsp)
  );
endmodule

FILE: hdl/bfa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/bfa_front.sv
// ----------------------------------------------------------------------------
// Allocator front end
// Accepts request words, decodes size and address, and queues commands.
// ----------------------------------------------------------------------------
module bfa_front
  import bfa_pkg::*;
#(
  parameter int unsigned MAP_BYTES = MAP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] user_base,
  bfa_req_if.sink     req,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);
  localparam logic [30:0] TOTAL = 31'(MAP_BYTES * 8);

  cmd_t        q_r [QUEUE_DEPTH];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [31:0] offset;
  cmd_t        dec;
  logic        push, pop;

  assign offset      = req.address - user_base;
  assign dec.is_free = (req.func == FUNC_FREE);
  assign dec.need    = {3'd0, req.size_bytes[9:2]} + 11'd1;
  assign dec.first   = offset[31:2];
  assign dec.bad     = (offset[1:0] != 2'd0) || ({1'b0, offset[31:2]} >= TOTAL);

  assign req.ready = (cnt_r != 2'(QUEUE_DEPTH));
  assign push      = req.valid && req.ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wp_r] <= dec;
    end
  end

`include "bitmap_first_fit_allocator_core_assert.svh"
  `BFA_ASSERT_IMPL(a_no_push_full, cnt_r == 2'(QUEUE_DEPTH), !push)
  `BFA_ASSERT_NEXT(a_cnt_grow, push && !pop, cnt_r == $past(cnt_r) + 2'd1)
  `BFA_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_r <= 2'(QUEUE_DEPTH))
endmodule

FILE: hdl/bfa_back.sv
// ----------------------------------------------------------------------------
// Allocator back end
// Scans the bitmap a bit per cycle between byte reads, updates it bit by bit.
// ----------------------------------------------------------------------------
module bfa_back
  import bfa_pkg::*;
#(
  parameter int unsigned MAP_BYTES = MAP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] user_base,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  bfa_rsp_if.source   rsp
);
  localparam int unsigned AW = $clog2(MAP_BYTES);
  localparam int unsigned GW = AW + 3;
  localparam logic [GW:0] TOTAL = (GW+1)'(MAP_BYTES * 8);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_RD    = 8'b00000100,
    S_SCAN  = 8'b00001000,
    S_WRD   = 8'b00010000,
    S_WR    = 8'b00100000,
    S_WWR   = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t      st_r, st_nxt;
  cmd_t        c_r, c_nxt;
  logic [GW:0] g_r, g_nxt;
  logic [10:0] run_r, run_nxt;
  logic [10:0] k_r, k_nxt;
  logic [GW:0] start_r, start_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [1:0]  stat_r, stat_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] oaddr_r, oaddr_nxt;
  logic [1:0]  ostat_r, ostat_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;
  logic          bit_used;
  logic [7:0]    mask;

  bfa_ram #(.WIDTH(8), .DEPTH(MAP_BYTES)) u_map (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign bit_used  = rdata[g_r[2:0]];
  assign mask      = 8'd1 << g_r[2:0];
  assign raddr     = g_nxt[GW-1:3];
  assign cmd_ready = (st_r == S_IDLE);
  assign rsp.valid = ov_r;
  assign rsp.block_address = oaddr_r;
  assign rsp.status        = ostat_r;

  always_comb begin
    st_nxt    = st_r;
    c_nxt     = c_r;
    g_nxt     = g_r;
    run_nxt   = run_r;
    k_nxt     = k_r;
    start_nxt = start_r;
    addr_nxt  = addr_r;
    stat_nxt  = stat_r;
    ov_nxt    = ov_r && !rsp.ready;
    oaddr_nxt = oaddr_r;
    ostat_nxt = ostat_r;
    we        = 1'b0;
    waddr     = g_r[GW-1:3];
    wdata     = rdata;
    case (st_r)
      S_CLEAR: begin
        we    = 1'b1;
        wdata = 8'd0;
        g_nxt = g_r + (GW+1)'(8);
        if (g_r[GW-1:3] == AW'(MAP_BYTES - 1)) begin
          st_nxt = S_IDLE;
          g_nxt  = '0;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          c_nxt    = cmd;
          addr_nxt = 32'd0;
          stat_nxt = ST_OK;
          run_nxt  = 11'd0;
          k_nxt    = 11'd0;
          if (cmd.is_free) begin
            if (cmd.bad) begin
              stat_nxt = ST_BAD_ADDRESS;
              st_nxt   = S_DONE;
            end else begin
              start_nxt = cmd.first[GW:0];
              g_nxt     = cmd.first[GW:0];
              st_nxt    = S_WRD;
            end
          end else begin
            g_nxt  = '0;
            st_nxt = S_RD;
          end
        end
      end
      S_RD: st_nxt = S_SCAN;
      S_SCAN: begin
        if (bit_used) begin
          run_nxt = 11'd0;
        end else begin
          run_nxt = run_r + 11'd1;
        end
        if (!bit_used && (run_r + 11'd1 == c_r.need)) begin
          start_nxt = g_r + (GW+1)'(1) - (GW+1)'(c_r.need);
          g_nxt     = g_r + (GW+1)'(1) - (GW+1)'(c_r.need);
          addr_nxt  = user_base + {(29-GW)'(0), g_r + (GW+1)'(1) - (GW+1)'(c_r.need), 2'b00};
          st_nxt    = S_WRD;
        end else if (g_r + (GW+1)'(1) == TOTAL) begin
          stat_nxt = ST_NO_SPACE;
          st_nxt   = S_DONE;
        end else begin
          g_nxt = g_r + (GW+1)'(1);
          st_nxt = (g_r[2:0] == 3'd7) ? S_RD : S_SCAN;
        end
      end
      S_WRD: st_nxt = S_WR;
      S_WR: begin
        // Modify the bit of the current granule and write its byte back.
        wdata = c_r.is_free ? (rdata & ~mask) : (rdata | mask);
        we    = 1'b1;
        k_nxt = k_r + 11'd1;
        g_nxt = g_r + (GW+1)'(1);
        if ((k_r + 11'd1 == c_r.need) || (g_r + (GW+1)'(1) == TOTAL)) begin
          st_nxt = S_DONE;
        end else begin
          st_nxt = (g_r[2:0] == 3'd7) ? S_WRD : S_WWR;
        end
      end
      S_WWR: st_nxt = S_WRD;
      S_DONE: begin
        if (!ov_r || rsp.ready) begin
          ov_nxt    = 1'b1;
          oaddr_nxt = addr_r;
          ostat_nxt = stat_r;
          st_nxt    = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR;
      g_r  <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      g_r  <= g_nxt;
      ov_r <= ov_nxt;
    end
    c_r     <= c_nxt;
    run_r   <= run_nxt;
    k_r     <= k_nxt;
    start_r <= start_nxt;
    addr_r  <= addr_nxt;
    stat_r  <= stat_nxt;
    oaddr_r <= oaddr_nxt;
    ostat_r <= ostat_nxt;
  end

`include "bitmap_first_fit_allocator_core_assert.svh"
  `BFA_ASSERT_IMPL(a_ready_idle, cmd_ready, !we)
  `BFA_ASSERT_IMPL(a_free_no_addr, ov_r && c_r.is_free, addr_r == 32'd0)
  `BFA_ASSERT_NEXT(a_done_out, st_r == S_DONE && st_nxt == S_IDLE, ov_r)
  `BFA_ASSERT_IMPL(a_start_ok, st_r == S_WR, start_r <= g_r)
endmodule
